>>> rtl/lpc_pkg.sv
// ---------------------------------------------------------------------------
// Level PI controller package
// Shared types, register codes, widths and the constant power table.
// ---------------------------------------------------------------------------
package lpc_pkg;

   // Fraction bits of the controller output accumulator.
   localparam int ACC_FRAC_BITS  = 30;
   // Number of intervals in the power table; the table has one more entry.
   localparam int POW_TABLE_SIZE = 256;
   localparam int ONE_FRAC_BITS  = 24;

   localparam int MV_W      = ACC_FRAC_BITS + 1;
   localparam int MAG_W     = ACC_FRAC_BITS + 2;
   localparam int MVS_W     = ACC_FRAC_BITS + 3;
   localparam int Q16_SHIFT = (ACC_FRAC_BITS > 16) ? ACC_FRAC_BITS - 16 : 0;
   localparam int Q16_RND   = (ACC_FRAC_BITS > 16) ? ACC_FRAC_BITS - 17 : 0;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 27;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int NUM_W     = 44;
   localparam int DEN_W     = 50;
   localparam int DIV_REM_W = DEN_W + 1;
   localparam int DIV_Q_W   = (ACC_FRAC_BITS + 1 > 31) ? ACC_FRAC_BITS + 1 : 31;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   // Flow balance divide by 10000 through a reciprocal multiplication. The
   // estimate is at most one low and is corrected by a compare and subtract.
   localparam int     BAL_DIVISOR     = 10000;
   localparam int     BAL_RECIP_SHIFT = 39;
   localparam longint BAL_RECIP       = (longint'(1) << BAL_RECIP_SHIFT) / BAL_DIVISOR;
   localparam int     BAL_Q_W         = 18;

   localparam int IDX_W = $clog2(POW_TABLE_SIZE + 1);
   localparam int TAB_W = 33;

   // Register indexes.
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_SETPOINT  = 3'd1;
   localparam logic [2:0] CSR_MINIMUM   = 3'd2;
   localparam logic [2:0] CSR_BAND      = 3'd3;
   localparam logic [2:0] CSR_ITIME     = 3'd4;
   localparam logic [2:0] CSR_IGAIN     = 3'd5;
   localparam logic [2:0] CSR_OMEGA_MAX = 3'd6;
   localparam logic [2:0] CSR_DRIVE_MAX = 3'd7;

   // Mode codes; every other code holds.
   localparam logic [2:0] MODE_BALANCE = 3'd2;
   localparam logic [2:0] MODE_THRU    = 3'd3;
   localparam logic [2:0] MODE_DRIVE   = 3'd4;

   typedef struct packed {
      logic [13:0] level;
      logic [15:0] flow_in;
      logic [15:0] tick_ms;
   } lpc_req_type;

   typedef struct packed {
      logic        active;
      logic [16:0] valve_out;
      logic [16:0] flow_out;
      logic [23:0] omega;
      logic [15:0] ext_drive;
   } lpc_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_REM_W-1:0] rem0;
      logic [DIV_Q_W-1:0]   q0;
      logic [DEN_W-1:0]     den;
   } lpc_div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lpc_div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BAL_MUL_FLOW,
      ST_BAL_MUL_ERR,
      ST_BAL_SUM,
      ST_BAL_DIV,
      ST_BAL_WAIT,
      ST_BAL_FIX,
      ST_PI_MUL_DE,
      ST_PI_MUL_TAU,
      ST_PI_MUL_TICK,
      ST_PI_SUM,
      ST_PI_MUL_DEN,
      ST_PI_DEN,
      ST_PI_SAT,
      ST_PI_WAIT,
      ST_PI_UPD,
      ST_PI_Q16,
      ST_DRV_MUL,
      ST_DRV_RES,
      ST_THR_POS,
      ST_THR_IDX,
      ST_THR_INTERP,
      ST_THR_VAL,
      ST_THR_MULW,
      ST_THR_RES,
      ST_DONE
   } lpc_state_type;

   typedef logic [TAB_W-1:0] pow_tab_type [0:POW_TABLE_SIZE];

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] xv;
      r  = '0;
      b  = 64'd1 << 62;
      xv = x;
      while (b > xv) b = b >> 2;
      while (b != 0) begin
         if (xv >= r + b) begin
            xv = xv - (r + b);
            r  = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Entry k holds 10^(5*(k/N-1)) in Q1.32, built from repeated square roots
   // of one tenth for the fraction and decimal steps for the integer part.
   function automatic pow_tab_type build_pow_tab();
      logic [63:0] root [0:ONE_FRAC_BITS];
      logic [63:0] g;
      logic [63:0] d;
      logic [63:0] f;
      logic [63:0] p;
      pow_tab_type t;
      root[0] = 64'd429496730;
      for (int i = 1; i <= ONE_FRAC_BITS; i++) root[i] = isqrt64(root[i-1] << 32);
      for (int k = 0; k <= POW_TABLE_SIZE; k++) begin
         g = (64'(5 * (POW_TABLE_SIZE - k)) << ONE_FRAC_BITS) / POW_TABLE_SIZE;
         d = g >> ONE_FRAC_BITS;
         f = g & ((64'd1 << ONE_FRAC_BITS) - 64'd1);
         p = 64'd1 << 32;
         for (int i = 1; i <= ONE_FRAC_BITS; i++)
            if (f[ONE_FRAC_BITS-i]) p = (p * root[i]) >> 32;
         for (longint j = 0; j < longint'(d); j++) p = (p + 64'd5) / 10;
         t[k] = p[TAB_W-1:0];
      end
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

   // Controller output rounded half up to Q1.16.
   function automatic logic [16:0] mv_to_q16(input logic [MV_W-1:0] acc);
      logic [MV_W:0] sum;
      sum = {1'b0, acc} + ((MV_W+1)'(1) << Q16_RND);
      if (ACC_FRAC_BITS > 16) return 17'(sum >> Q16_SHIFT);
      return 17'(acc);
   endfunction

endpackage

>>> rtl/level_pi_controller_core.sv
// A flow balance tick ends early when the sum is not positive; a PI tick
// runs more states for throughput than for external drive and skips the
// divider when the step saturates. Throughput: one tick at a time; the 31
// steps of the bit-serial divider dominate the PI tick. A finished result
// waits in an output register while the next tick is taken. Reset
// (synchronous) restores register defaults and clears state and output valid.
// ---------------------------------------------------------------------------
// Level PI controller core
// Flow balance and velocity-form PI level control with throughput and
// external drive outputs, sequenced over one multiplier and one divider.
// ---------------------------------------------------------------------------
module level_pi_controller_core import lpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lpc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lpc_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [MV_W-1:0] MV_ONE = MV_W'(1) << ACC_FRAC_BITS;

   // Configuration registers.
   logic [2:0]  mode_ff, mode_in;
   logic [13:0] setpoint_ff, setpoint_in;
   logic [13:0] minimum_ff, minimum_in;
   logic [9:0]  band_ff, band_in;
   logic [15:0] itime_ff, itime_in;
   logic [15:0] igain_ff, igain_in;
   logic [15:0] omega_max_ff, omega_max_in;
   logic [15:0] drive_max_ff, drive_max_in;

   // Sequencer and controller state.
   lpc_state_type      state_ff, state_in;
   logic [MV_W-1:0]    mv_acc_ff, mv_acc_in;
   logic signed [14:0] prev_err_ff, prev_err_in;
   logic [16:0]        held_flow_ff, held_flow_in;
   logic [23:0]        held_omega_ff, held_omega_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers of the current tick.
   lpc_req_type        req_ff, req_in;
   logic signed [14:0] err_ff, err_in;
   logic               active_ff, active_in;
   logic [15:0]        drive_ff, drive_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0]   abs_ff, abs_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [16:0]        q16_ff, q16_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [15:0]        fr_ff, fr_in;
   logic [TAB_W-1:0]   lo_ff, lo_in;
   logic [TAB_W-1:0]   val_ff, val_in;
   lpc_rsp_type        rsp_ff, rsp_in;

   // Shared units.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   lpc_div_cmd_type           div_cmd;
   lpc_div_stat_type          div_stat;
   logic [DIV_Q_W-1:0]        quot;

   // Combinational helpers.
   logic               accept;
   logic signed [14:0] err_now;
   logic signed [15:0] de;
   logic [9:0]         band_eff;
   logic [15:0]        tau_eff;
   logic [30:0]        bal_rnd;
   logic [30:0]        bal_rem;
   logic [BAL_Q_W-1:0] bal_q;
   logic signed [MVS_W-1:0] mv_sum;
   logic [IDX_W-1:0]   idx_nx;
   logic [TAB_W-1:0]   tab_lo;
   logic [TAB_W-1:0]   tab_hi;
   logic [32:0]        drive_sum;
   logic [48:0]        omega_sum;

   lpc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   lpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_stat (div_stat),
      .quot     (quot)
   );

   // Configuration writes are decoded straight into the registers; fields
   // narrower than the data bus take the low bits.
   always_comb begin
      mode_in      = mode_ff;
      setpoint_in  = setpoint_ff;
      minimum_in   = minimum_ff;
      band_in      = band_ff;
      itime_in     = itime_ff;
      igain_in     = igain_ff;
      omega_max_in = omega_max_ff;
      drive_max_in = drive_max_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:      mode_in      = csr_wdata[2:0];
            CSR_SETPOINT:  setpoint_in  = csr_wdata[13:0];
            CSR_MINIMUM:   minimum_in   = csr_wdata[13:0];
            CSR_BAND:      band_in      = csr_wdata[9:0];
            CSR_ITIME:     itime_in     = csr_wdata;
            CSR_IGAIN:     igain_in     = csr_wdata;
            CSR_OMEGA_MAX: omega_max_in = csr_wdata;
            CSR_DRIVE_MAX: drive_max_in = csr_wdata;
            default:       mode_in      = mode_ff;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // The level error; levels over range are taken as given and still fit.
   assign err_now = $signed({1'b0, req_data.level}) - $signed({1'b0, setpoint_ff});

   // A previous error of exactly zero marks a fresh start: no error step.
   assign de = (prev_err_ff == '0) ? '0
             : $signed({err_ff[14], err_ff}) - $signed({prev_err_ff[14], prev_err_ff});

   // A band or integral time of zero behaves as one.
   assign band_eff = (band_ff == '0) ? 10'd1 : band_ff;
   assign tau_eff  = (itime_ff == '0) ? 16'd1 : itime_ff;

   assign idx_nx = idx_ff + IDX_W'(1);
   assign tab_lo = POW_TAB[idx_ff];
   assign tab_hi = POW_TAB[idx_nx];

   always_comb begin
      state_in      = state_ff;
      mv_acc_in     = mv_acc_ff;
      prev_err_in   = prev_err_ff;
      held_flow_in  = held_flow_ff;
      held_omega_in = held_omega_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_in        = req_ff;
      err_in        = err_ff;
      active_in     = active_ff;
      drive_in      = drive_ff;
      num_in        = num_ff;
      abs_in        = abs_ff;
      den_in        = den_ff;
      mag_in        = mag_ff;
      q16_in        = q16_ff;
      idx_in        = idx_ff;
      fr_in         = fr_ff;
      lo_in         = lo_ff;
      val_in        = val_ff;
      rsp_in        = rsp_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_cmd       = '0;
      bal_rnd       = num_ff[30:0] + 31'd5000;
      bal_rem       = '0;
      bal_q         = '0;
      mv_sum        = '0;
      drive_sum     = prod[32:0] + 33'd32768;
      omega_sum     = {1'b0, prod[47:0]} + 49'h80_0000;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               err_in    = err_now;
               drive_in  = '0;
               active_in = 1'b0;
               unique case (mode_ff)
                  MODE_BALANCE: begin
                     active_in = 1'b1;
                     state_in  = ST_BAL_MUL_FLOW;
                  end
                  MODE_THRU, MODE_DRIVE: begin
                     active_in = 1'b1;
                     state_in  = ST_PI_MUL_DE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // Flow balance: flow_in*10000 + e*gain, then a rounded divide by
         // 10000 done as a reciprocal multiply and one correction step.
         ST_BAL_MUL_FLOW: begin
            mul_a    = MUL_A_W'(req_ff.flow_in);
            mul_b    = MUL_B_W'(10000);
            state_in = ST_BAL_MUL_ERR;
         end
         ST_BAL_MUL_ERR: begin
            num_in   = prod[NUM_W-1:0];
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = $signed({11'b0, igain_ff});
            state_in = ST_BAL_SUM;
         end
         ST_BAL_SUM: begin
            num_in   = num_ff + $signed(prod[NUM_W-1:0]);
            state_in = ST_BAL_DIV;
         end
         ST_BAL_DIV: begin
            if (num_ff <= 0) begin
               held_flow_in = '0;
               state_in     = ST_DONE;
            end else begin
               mul_a    = MUL_A_W'(bal_rnd);
               mul_b    = MUL_B_W'(BAL_RECIP);
               state_in = ST_BAL_WAIT;
            end
         end
         ST_BAL_WAIT: begin
            // The estimate is the true quotient or one below it.
            abs_in   = NUM_W'(prod[BAL_RECIP_SHIFT +: BAL_Q_W]);
            mul_a    = MUL_A_W'(prod[BAL_RECIP_SHIFT +: BAL_Q_W]);
            mul_b    = MUL_B_W'(BAL_DIVISOR);
            state_in = ST_BAL_FIX;
         end
         ST_BAL_FIX: begin
            bal_rem      = bal_rnd - prod[30:0];
            bal_q        = abs_ff[BAL_Q_W-1:0]
                         + ((bal_rem >= 31'(BAL_DIVISOR)) ? BAL_Q_W'(1) : BAL_Q_W'(0));
            held_flow_in = (bal_q > BAL_Q_W'(131071)) ? 17'd131071 : bal_q[16:0];
            state_in     = ST_DONE;
         end

         // PI step: num = de*1000*tau + tick*e, den = band*tau*1e7.
         ST_PI_MUL_DE: begin
            mul_a    = MUL_A_W'(de);
            mul_b    = MUL_B_W'(1000);
            state_in = ST_PI_MUL_TAU;
         end
         ST_PI_MUL_TAU: begin
            mul_a    = prod[MUL_A_W-1:0];
            mul_b    = $signed({11'b0, tau_eff});
            state_in = ST_PI_MUL_TICK;
         end
         ST_PI_MUL_TICK: begin
            num_in   = prod[NUM_W-1:0];
            mul_a    = MUL_A_W'(req_ff.tick_ms);
            mul_b    = MUL_B_W'(err_ff);
            state_in = ST_PI_SUM;
         end
         ST_PI_SUM: begin
            num_in   = num_ff + $signed(prod[NUM_W-1:0]);
            mul_a    = MUL_A_W'(band_eff);
            mul_b    = $signed({11'b0, tau_eff});
            state_in = ST_PI_MUL_DEN;
         end
         ST_PI_MUL_DEN: begin
            mul_a    = prod[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(10000000);
            state_in = ST_PI_DEN;
         end
         ST_PI_DEN: begin
            den_in   = prod[DEN_W-1:0];
            abs_in   = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
            state_in = ST_PI_SAT;
         end
         ST_PI_SAT: begin
            // A step of two full scales or more saturates the increment.
            if (DIV_REM_W'(abs_ff) >= {den_ff, 1'b0}) begin
               mag_in   = MAG_W'(2) << ACC_FRAC_BITS;
               state_in = ST_PI_UPD;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = DIV_CNT_W'(ACC_FRAC_BITS + 1);
               div_cmd.rem0  = DIV_REM_W'(abs_ff);
               div_cmd.q0    = '0;
               div_cmd.den   = den_ff;
               state_in      = ST_PI_WAIT;
            end
         end
         ST_PI_WAIT: begin
            if (div_stat.done) begin
               mag_in   = {1'b0, quot[ACC_FRAC_BITS:0]};
               state_in = ST_PI_UPD;
            end
         end
         ST_PI_UPD: begin
            if (num_ff[NUM_W-1]) begin
               mv_sum = $signed({2'b0, mv_acc_ff}) - $signed({1'b0, mag_ff});
            end else begin
               mv_sum = $signed({2'b0, mv_acc_ff}) + $signed({1'b0, mag_ff});
            end
            if (mv_sum < 0) begin
               mv_acc_in = '0;
            end else if (mv_sum > $signed(MVS_W'(MV_ONE))) begin
               mv_acc_in = MV_ONE;
            end else begin
               mv_acc_in = mv_sum[MV_W-1:0];
            end
            if (req_ff.level < minimum_ff) mv_acc_in = '0;
            prev_err_in = err_ff;
            state_in    = ST_PI_Q16;
         end
         ST_PI_Q16: begin
            q16_in   = mv_to_q16(mv_acc_ff);
            state_in = (mode_ff == MODE_THRU) ? ST_THR_POS : ST_DRV_MUL;
         end

         // External drive: round(mv * drive_max).
         ST_DRV_MUL: begin
            mul_a    = MUL_A_W'(q16_ff);
            mul_b    = $signed({11'b0, drive_max_ff});
            state_in = ST_DRV_RES;
         end
         ST_DRV_RES: begin
            drive_in = drive_sum[31:16];
            state_in = ST_DONE;
         end

         // Throughput: interpolate the power table at mv*N, scale by omega_max.
         ST_THR_POS: begin
            mul_a    = MUL_A_W'(q16_ff);
            mul_b    = MUL_B_W'(POW_TABLE_SIZE);
            state_in = ST_THR_IDX;
         end
         ST_THR_IDX: begin
            idx_in   = prod[16 +: IDX_W];
            fr_in    = prod[15:0];
            state_in = ST_THR_INTERP;
         end
         ST_THR_INTERP: begin
            if (idx_ff >= IDX_W'(POW_TABLE_SIZE)) begin
               val_in   = POW_TAB[POW_TABLE_SIZE];
               state_in = ST_THR_MULW;
            end else begin
               lo_in    = tab_lo;
               mul_a    = $signed({1'b0, tab_hi - tab_lo});
               mul_b    = $signed({11'b0, fr_ff});
               state_in = ST_THR_VAL;
            end
         end
         ST_THR_VAL: begin
            val_in   = lo_ff + prod[16 +: TAB_W];
            state_in = ST_THR_MULW;
         end
         ST_THR_MULW: begin
            mul_a    = $signed({1'b0, val_ff});
            mul_b    = $signed({11'b0, omega_max_ff});
            state_in = ST_THR_RES;
         end
         ST_THR_RES: begin
            held_omega_in = omega_sum[48] ? 24'hFF_FFFF : omega_sum[47:24];
            state_in      = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.active    = active_ff;
               rsp_in.valve_out = mv_to_q16(mv_acc_ff);
               rsp_in.flow_out  = held_flow_ff;
               rsp_in.omega     = held_omega_ff;
               rsp_in.ext_drive = drive_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 3'd0;
         setpoint_ff   <= 14'd5000;
         minimum_ff    <= 14'd1500;
         band_ff       <= 10'd20;
         itime_ff      <= 16'd200;
         igain_ff      <= 16'd1000;
         omega_max_ff  <= 16'd10000;
         drive_max_ff  <= 16'd100;
         state_ff      <= ST_IDLE;
         mv_acc_ff     <= '0;
         prev_err_ff   <= '0;
         held_flow_ff  <= '0;
         held_omega_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         setpoint_ff   <= setpoint_in;
         minimum_ff    <= minimum_in;
         band_ff       <= band_in;
         itime_ff      <= itime_in;
         igain_ff      <= igain_in;
         omega_max_ff  <= omega_max_in;
         drive_max_ff  <= drive_max_in;
         state_ff      <= state_in;
         mv_acc_ff     <= mv_acc_in;
         prev_err_ff   <= prev_err_in;
         held_flow_ff  <= held_flow_in;
         held_omega_ff <= held_omega_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      err_ff    <= err_in;
      active_ff <= active_in;
      drive_ff  <= drive_in;
      num_ff    <= num_in;
      abs_ff    <= abs_in;
      den_ff    <= den_in;
      mag_ff    <= mag_in;
      q16_ff    <= q16_in;
      idx_ff    <= idx_in;
      fr_ff     <= fr_in;
      lo_ff     <= lo_in;
      val_ff    <= val_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      mv_acc_ff <= MV_ONE)
      else $error("controller output accumulator above one");

   a_valve_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.valve_out <= 17'd65536)
      else $error("valve output above one");

   a_drive_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.active) |-> rsp_ff.ext_drive == '0)
      else $error("drive reported on an inactive tick");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while the sequencer is idle");
`endif

endmodule

>>> rtl/lpc_mul.sv
// ---------------------------------------------------------------------------
// Level PI controller multiplier
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module lpc_mul import lpc_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/lpc_div.sv
// ---------------------------------------------------------------------------
// Level PI controller divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lpc_div import lpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  lpc_div_cmd_type      div_cmd,
   output lpc_div_stat_type     div_stat,
   output logic [DIV_Q_W-1:0]   quot
);

   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 ge;
   logic [DIV_REM_W-1:0] diff;

   // Each step compares, subtracts on success, then shifts the next
   // dividend bit into the remainder and the quotient bit into q.
   always_comb begin
      ge      = rem_ff >= {1'b0, den_ff};
      diff    = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         rem_in = div_cmd.rem0;
         q_in   = div_cmd.q0;
         den_in = div_cmd.den;
         cnt_in = div_cmd.steps;
      end else if (cnt_ff != '0) begin
         rem_in  = {diff[DIV_REM_W-2:0], q_ff[DIV_Q_W-1]};
         q_in    = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign div_stat.busy = (cnt_ff != '0);
   assign div_stat.done = done_ff;
   assign quot          = q_ff;

endmodule

>>> tb/tb_level_pi_controller_core.sv
// ---------------------------------------------------------------------------
// Level PI controller core testbench
// Drives control ticks through the request channel under random idling and
// back pressure, walks the registers through many settings, and compares
// every result against an in-bench model of the flow balance, the PI
// controller and the throughput table.
// ---------------------------------------------------------------------------
module tb_level_pi_controller_core;
   import lpc_pkg::*;

   localparam int          FRAC      = 30;
   localparam int          TAB_N     = 256;
   localparam int          CYCLE_CAP = 600000;
   localparam longint      ACC_ONE   = 64'sd1 << FRAC;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lpc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lpc_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_MODE;
   logic [15:0] csr_wdata = '0;

   always #1 clock = ~clock;

   level_pi_controller_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Register copies as the block should hold them.
   logic [2:0]  cfg_mode;
   logic [13:0] cfg_setpoint, cfg_minimum;
   logic [9:0]  cfg_band;
   logic [15:0] cfg_itime, cfg_igain, cfg_omega_max, cfg_drive_max;

   // Controller state of the model.
   longint      valve_acc;
   int          last_error;
   logic [16:0] kept_flow;
   logic [23:0] kept_omega;

   longint unsigned power_table [0:TAB_N];

   lpc_req_type tick_queue [$];
   lpc_rsp_type expected_rsp [$];

   // When set, neither side inserts idle cycles.
   bit     no_idle = 1'b0;
   int     send_gap = 0;
   int     stall_left = 0;
   int     errors = 0;
   int     ticks_sent = 0;
   int     results_seen = 0;
   // Ticks queued whose result has not yet been transferred.
   int     outstanding = 0;
   int     cycles = 0;
   int     mode_hits [0:7];

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Table of 10^(5*(k/N-1)) in Q1.32: square roots of one tenth cover the
   // fractional exponent, repeated rounded division by ten the integer part.
   function automatic void fill_power_table();
      longint unsigned roots [0:24];
      longint unsigned g, d, f, p;
      roots[0] = 64'd429496730;
      for (int i = 1; i <= 24; i++) roots[i] = int_sqrt(roots[i-1] << 32);
      for (int k = 0; k <= TAB_N; k++) begin
         g = (longint'(5 * (TAB_N - k)) << 24) / TAB_N;
         d = g >> 24;
         f = g & ((64'd1 << 24) - 1);
         p = 64'd1 << 32;
         for (int i = 1; i <= 24; i++)
            if ((f >> (24 - i)) & 1) p = (p * roots[i]) >> 32;
         for (longint unsigned j = 0; j < d; j++) p = (p + 5) / 10;
         power_table[k] = p;
      end
   endfunction

   function automatic logic [16:0] valve_q16();
      return 17'((valve_acc + (64'sd1 << (FRAC - 17))) >> (FRAC - 16));
   endfunction

   // Velocity-form PI step: the increment is truncated toward zero to FRAC
   // fraction bits, saturated at two full scales, then clamped to [0,1].
   function automatic void pi_step(input int err, input int lvl, input int tick);
      longint band, tau, de, num, den, mag, q, rem, frac, nxt;
      band = (cfg_band == 0) ? 1 : cfg_band;
      tau  = (cfg_itime == 0) ? 1 : cfg_itime;
      de   = (last_error == 0) ? 0 : longint'(err) - last_error;
      num  = de * 1000 * tau + longint'(tick) * err;
      den  = band * tau * 10000000;
      q    = (num < 0 ? -num : num) / den;
      rem  = (num < 0 ? -num : num) % den;
      frac = 0;
      last_error = err;
      if (q >= 2) begin
         mag = 64'sd2 << FRAC;
      end else begin
         for (int i = 0; i < FRAC; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
               rem  = rem - den;
               frac = frac | 1;
            end
         end
         mag = (q << FRAC) + frac;
      end
      nxt = valve_acc + (num < 0 ? -mag : mag);
      if (nxt < 0) nxt = 0;
      if (nxt > ACC_ONE) nxt = ACC_ONE;
      if (lvl < cfg_minimum) nxt = 0;
      valve_acc = nxt;
   endfunction

   function automatic logic [23:0] throughput_of(input logic [16:0] v16);
      longint unsigned pos, idx, fr, val, prod;
      longint diff;
      pos = longint'(v16) * TAB_N;
      idx = pos >> 16;
      fr  = pos & 16'hFFFF;
      if (idx >= TAB_N) begin
         val = power_table[TAB_N];
      end else begin
         diff = longint'(power_table[idx+1]) - longint'(power_table[idx]);
         val  = longint'(power_table[idx]) + diff * longint'(fr) / 65536;
      end
      prod = (longint'(cfg_omega_max) * 256 * val + (64'd1 << 31)) >> 32;
      return (prod > 24'hFFFFFF) ? 24'hFFFFFF : 24'(prod);
   endfunction

   // Works out the result of one accepted tick and updates the model state.
   function automatic void predict_tick(input lpc_req_type t);
      lpc_rsp_type r;
      int err;
      longint num, flow;
      err = int'(t.level) - int'(cfg_setpoint);
      r = '0;
      mode_hits[cfg_mode]++;
      if (cfg_mode == MODE_BALANCE) begin
         num  = longint'(t.flow_in) * 10000 + longint'(err) * cfg_igain;
         flow = (num > 0) ? (num + 5000) / 10000 : 0;
         kept_flow = (flow > 131071) ? 17'd131071 : 17'(flow);
         r.active = 1'b1;
      end else if (cfg_mode == MODE_THRU || cfg_mode == MODE_DRIVE) begin
         pi_step(err, t.level, t.tick_ms);
         if (cfg_mode == MODE_THRU) kept_omega = throughput_of(valve_q16());
         else r.ext_drive = 16'((longint'(valve_q16()) * cfg_drive_max + 32768) >> 16);
         r.active = 1'b1;
      end
      r.valve_out = valve_q16();
      r.flow_out  = kept_flow;
      r.omega     = kept_omega;
      expected_rsp.push_back(r);
   endfunction

   // Sender: a new tick is presented only once the previous transfer is done
   // and its idle gap has run out, so valid and data hold while stalled.
   always @(posedge clock) begin
      bit waiting;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         waiting = req_valid;
         if (req_valid && !req_stall) begin
            predict_tick(req_data);
            ticks_sent++;
            waiting = 1'b0;
         end
         if (!waiting) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               req_data  <= tick_queue.pop_front();
               req_valid <= 1'b1;
               send_gap = no_idle ? 0 : $urandom_range(0, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transfer and draws a stall after it.
   always @(posedge clock) begin
      lpc_rsp_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            outstanding--;
            stall_left = no_idle ? 0 : $urandom_range(0, 12);
            if (expected_rsp.size() == 0) begin
               $error("result transfer with no tick outstanding");
               errors++;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_data.active !== exp_r.active) begin
                  $error("active: expected %0d, got %0d", exp_r.active, rsp_data.active);
                  errors++;
               end
               if (rsp_data.valve_out !== exp_r.valve_out) begin
                  $error("valve_out: expected %0d, got %0d",
                         exp_r.valve_out, rsp_data.valve_out);
                  errors++;
               end
               if (rsp_data.flow_out !== exp_r.flow_out) begin
                  $error("flow_out: expected %0d, got %0d",
                         exp_r.flow_out, rsp_data.flow_out);
                  errors++;
               end
               if (rsp_data.omega !== exp_r.omega) begin
                  $error("omega: expected %0d, got %0d", exp_r.omega, rsp_data.omega);
                  errors++;
               end
               if (rsp_data.ext_drive !== exp_r.ext_drive) begin
                  $error("ext_drive: expected %0d, got %0d",
                         exp_r.ext_drive, rsp_data.ext_drive);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("level_pi_controller_core verification failed");
         $finish;
      end
   end

   // Register writes happen only while the block is idle, so the model
   // copy can be updated at once.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:      cfg_mode      = val[2:0];
         CSR_SETPOINT:  cfg_setpoint  = val[13:0];
         CSR_MINIMUM:   cfg_minimum   = val[13:0];
         CSR_BAND:      cfg_band      = val[9:0];
         CSR_ITIME:     cfg_itime     = val;
         CSR_IGAIN:     cfg_igain     = val;
         CSR_OMEGA_MAX: cfg_omega_max = val;
         default:       cfg_drive_max = val;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every queued tick has returned its result, then idles
   // before the registers change.
   task automatic drain();
      while (outstanding > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_tick(input int lvl, input int flow, input int tick);
      lpc_req_type t;
      t.level   = 14'(lvl);
      t.flow_in = 16'(flow);
      t.tick_ms = 16'(tick);
      tick_queue.push_back(t);
      outstanding++;
   endtask

   // Mostly random values, with the two ends of the field's range often.
   function automatic int edgy(input int width);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return (1 << width) - 1;
         default: return $urandom_range(0, (1 << width) - 1);
      endcase
   endfunction

   initial begin
      int lvl, sp;
      cfg_mode = 0; cfg_setpoint = 5000; cfg_minimum = 1500; cfg_band = 20;
      cfg_itime = 200; cfg_igain = 1000; cfg_omega_max = 10000; cfg_drive_max = 100;
      valve_acc = 0; last_error = 0; kept_flow = 0; kept_omega = 0;
      for (int m = 0; m < 8; m++) mode_hits[m] = 0;
      fill_power_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Hold mode straight after reset, with field extremes.
      add_tick(0, 0, 0);
      add_tick(16383, 65535, 65535);
      drain();

      // Flow balance: extremes of flow and error, clamp at zero and at top.
      write_reg(CSR_MODE, 16'(MODE_BALANCE));
      write_reg(CSR_IGAIN, 16'hFFFF);
      end_writes();
      add_tick(0, 0, 5);
      add_tick(16383, 65535, 0);
      add_tick(5000, 1234, 7);
      add_tick(10000, 65535, 1);
      drain();

      // Throughput: a fresh start, a big step, the level
      // minimum, and levels over range.
      write_reg(CSR_MODE, 16'(MODE_THRU));
      write_reg(CSR_IGAIN, 16'd0);
      end_writes();
      add_tick(10000, 0, 65535);
      add_tick(0, 0, 65535);
      add_tick(16383, 0, 65535);
      add_tick(16383, 0, 65535);
      add_tick(1000, 0, 100);
      add_tick(6000, 0, 1000);
      drain();

      // External drive with zero band and zero integral time (both act as 1).
      write_reg(CSR_MODE, 16'(MODE_DRIVE));
      write_reg(CSR_BAND, 16'd0);
      write_reg(CSR_ITIME, 16'd0);
      write_reg(CSR_DRIVE_MAX, 16'hFFFF);
      end_writes();
      add_tick(9000, 0, 10);
      add_tick(4000, 0, 10);
      add_tick(5000, 0, 0);
      drain();

      // Unused mode codes hold.
      for (int m = 5; m < 8; m++) begin
         write_reg(CSR_MODE, 16'(m));
         end_writes();
         add_tick(16383, 65535, 65535);
         drain();
      end

      // Random phases: fresh settings, then a run of ticks around the setpoint.
      for (int ph = 0; ph < 18; ph++) begin
         write_reg(CSR_MODE, ($urandom_range(0, 5) == 0) ? 16'(edgy(3))
                                                          : 16'($urandom_range(2, 4)));
         write_reg(CSR_SETPOINT, ($urandom_range(0, 3) == 0) ? 16'(edgy(14))
                                                             : 16'($urandom_range(0, 10000)));
         write_reg(CSR_MINIMUM, ($urandom_range(0, 2) == 0) ? 16'(edgy(14))
                                                            : 16'($urandom_range(0, 3000)));
         write_reg(CSR_BAND, ($urandom_range(0, 2) == 0) ? 16'(edgy(10))
                                                         : 16'($urandom_range(1, 100)));
         write_reg(CSR_ITIME, ($urandom_range(0, 2) == 0) ? 16'(edgy(16))
                                                          : 16'($urandom_range(1, 1000)));
         write_reg(CSR_IGAIN, 16'(edgy(16)));
         write_reg(CSR_OMEGA_MAX, 16'(edgy(16)));
         write_reg(CSR_DRIVE_MAX, 16'(edgy(16)));
         end_writes();
         no_idle = (ph % 5 == 4);
         sp = cfg_setpoint;
         for (int n = 0; n < 22; n++) begin
            if ($urandom_range(0, 7) == 0) lvl = edgy(14);
            else begin
               lvl = sp + $signed($urandom_range(0, 4000)) - 2000;
               if (lvl < 0) lvl = 0;
               if (lvl > 16383) lvl = 16383;
            end
            add_tick(lvl, edgy(16), ($urandom_range(0, 3) == 0) ? edgy(16)
                                                                : $urandom_range(0, 5000));
         end
         drain();
         no_idle = 1'b0;
      end

      $display("Ran %0d ticks, %0d results checked over %0d register settings.",
               ticks_sent, results_seen, 18 + 7);
      $display("Tick counts by mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("level_pi_controller_core verification clean");
      end else begin
         $display("level_pi_controller_core verification failed");
      end
      $finish;
   end

endmodule

>>> level_pi_controller_core.f
rtl/lpc_pkg.sv
rtl/lpc_mul.sv
rtl/lpc_div.sv
rtl/level_pi_controller_core.sv
tb/tb_level_pi_controller_core.sv
